[rtl/imabd_pkg.sv]
// Shared types, constants and tables for the IMA ADPCM block decoder.
// No dependencies; imported by the decoder top level and the nibble datapath.
`timescale 1ns / 1ps
package imabd_pkg;

	// Register map (index in the register list; byte address is 4 * index).
	localparam logic REG_BLOCK_BYTES = 1'b0;

	localparam int BLOCK_BYTES_W = 13;
	localparam logic [BLOCK_BYTES_W-1:0] BLOCK_BYTES_RESET = 13'd36;
	localparam logic [BLOCK_BYTES_W-1:0] MIN_BLOCK_BYTES = 13'd5;

	localparam logic [6:0] INDEX_MAX = 7'd88;
	localparam logic signed [17:0] PRED_MAX = 18'sd32767;
	localparam logic signed [17:0] PRED_MIN = -18'sd32768;

	// What a byte held in the decode stage does, by its place in the block.
	localparam logic [2:0] KIND_HDR_LO  = 3'd0;
	localparam logic [2:0] KIND_HDR_HI  = 3'd1;
	localparam logic [2:0] KIND_INDEX   = 3'd2;
	localparam logic [2:0] KIND_SKIP    = 3'd3;
	localparam logic [2:0] KIND_PAYLOAD = 3'd4;

	// Decoder state carried from one nibble to the next.
	typedef struct packed {
		logic signed [15:0] pred;
		logic [6:0]         idx;
	} imabd_state_t;

	// Standard IMA step size table, 89 entries.
	function automatic logic [14:0] step_size(input logic [6:0] idx);
		logic [14:0] s;
		case (idx)
			7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
			7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
			7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
			7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
			7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
			7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
			7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
			7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
			7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
			7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
			7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
			7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
			7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
			7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
			7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
			7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
			7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
			7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
			7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
			7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
			7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
			7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
			7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
			7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
			7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
			7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
			7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
			7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
			7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
			7'd87: s = 15'd29794;
			default: s = 15'd32767;
		endcase
		return s;
	endfunction

	// Step index adjustment; the sign bit of the nibble does not matter.
	function automatic logic signed [7:0] index_adjust(input logic [2:0] mag);
		logic signed [7:0] a;
		case (mag)
			3'd4:    a = 8'sd2;
			3'd5:    a = 8'sd4;
			3'd6:    a = 8'sd6;
			3'd7:    a = 8'sd8;
			default: a = -8'sd1;
		endcase
		return a;
	endfunction

endpackage

[rtl/ima_adpcm_block_decoder.sv]
// Top level of the IMA ADPCM block decoder: block framing, decode stage, output register.
// Depends on imabd_pkg and instantiates imabd_nibble.
`timescale 1ns / 1ps
// Usage
// Input stream (s_*): one compressed byte per transfer, s_tlast marks the last byte of
// the stream, after which the next byte starts a new block. Output stream (m_*): one
// 16-bit PCM sample per transfer, m_tuser high on the high-nibble sample of a byte.
// The APB port holds block_bytes at address 0 (bytes per block, header included);
// write it only while the decoder is idle. Values below 5 make the decoder drop every
// byte; values above MAX_BLOCK_BYTES act as MAX_BLOCK_BYTES.
// Timing: a byte is registered into the decode stage on its transfer. Header bytes
// are applied there and give no sample. A payload byte is taken one nibble at a time,
// since each nibble's predictor depends on the previous one; each nibble is decoded
// combinationally and written to the output register, so the low-nibble sample passes
// the decode stage register and then the output register, and the high-nibble sample
// follows it as it is taken. The single nibble datapath and the one-sample output let
// a new byte follow a payload byte only as that byte's high nibble goes out.
// When the receiver stalls, the sample waits in the output register and the decode
// stage holds; s_tready falls once that stage holds a byte it cannot finish.
// Reset clears the block position, predictor, step index and all valid flags and
// sets block_bytes to 36.
module ima_adpcm_block_decoder
	import imabd_pkg::*;
#(
	parameter int MAX_BLOCK_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_stream
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] sample
	output logic        m_tuser,   // [0] last_of_byte
	// Configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int POS_W = (MAX_BLOCK_BYTES > 2) ? $clog2(MAX_BLOCK_BYTES) : 1;
	localparam int CMP_W = (POS_W > BLOCK_BYTES_W) ? POS_W + 1 : BLOCK_BYTES_W + 1;
	localparam logic [CMP_W-1:0] MAX_SIZE = CMP_W'(MAX_BLOCK_BYTES);

	logic [BLOCK_BYTES_W-1:0] block_bytes_q;
	logic [POS_W-1:0]         pos_q;
	imabd_state_t             dec_q;
	logic [7:0]               hdr_low_q;

	logic                     valid_s1;
	logic [2:0]               kind_s1;
	logic [7:0]               byte_s1;
	logic                     phase_s1;

	logic [15:0]              sample_q;
	logic                     last_q;
	logic                     out_valid_q;

	logic                     cfg_write;
	logic                     in_xfer;
	logic                     size_ok;
	logic [CMP_W-1:0]         size;
	logic [CMP_W-1:0]         pos_cur;
	logic [CMP_W-1:0]         pos_inc;
	logic [CMP_W-1:0]         pos_nxt;
	logic [2:0]               kind_in;
	logic                     out_free;
	logic                     s1_done;
	logic                     emit;
	logic [3:0]               nib;
	imabd_state_t             dec_nxt;

	// APB register access
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;
	assign prdata    = (paddr[2] == REG_BLOCK_BYTES) ? 32'(block_bytes_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q <= BLOCK_BYTES_RESET;
		end else if (cfg_write && paddr[2] == REG_BLOCK_BYTES) begin
			block_bytes_q <= pwdata[BLOCK_BYTES_W-1:0];
		end
	end

	// Block framing: effective size, position of the incoming byte, next position.
	always_comb begin
		size = CMP_W'(block_bytes_q);
		if (size > MAX_SIZE) begin
			size = MAX_SIZE;
		end
		size_ok = (block_bytes_q >= MIN_BLOCK_BYTES);
		pos_cur = CMP_W'(pos_q);
		if (pos_cur >= size) begin
			pos_cur = '0;
		end
		pos_inc = pos_cur + CMP_W'(1);
		pos_nxt = (pos_inc >= size || s_tlast) ? '0 : pos_inc;
		case (pos_cur)
			CMP_W'(0): kind_in = KIND_HDR_LO;
			CMP_W'(1): kind_in = KIND_HDR_HI;
			CMP_W'(2): kind_in = KIND_INDEX;
			CMP_W'(3): kind_in = KIND_SKIP;
			default:   kind_in = KIND_PAYLOAD;
		endcase
	end

	// The decode stage frees up when a header byte is applied or the
	// high nibble of a payload byte goes to the output register.
	assign out_free = !out_valid_q || m_tready;
	assign emit     = valid_s1 && (kind_s1 == KIND_PAYLOAD) && out_free;
	assign s1_done  = valid_s1 && ((kind_s1 != KIND_PAYLOAD) || (phase_s1 && out_free));
	assign s_tready = !valid_s1 || s1_done;
	assign in_xfer  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_xfer && size_ok) begin
			pos_q <= pos_nxt[POS_W-1:0];
		end
	end

	// Decode stage input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= size_ok && (kind_in != KIND_SKIP);
			phase_s1 <= 1'b0;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
		end else if (emit) begin
			phase_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= s_tdata;
			kind_s1 <= kind_in;
		end
	end

	// One nibble per cycle through the shared datapath, while the output register is free.
	assign nib = phase_s1 ? byte_s1[7:4] : byte_s1[3:0];

	imabd_nibble u_nibble (
		.cur (dec_q),
		.nib (nib),
		.nxt (dec_nxt)
	);

	// Decoder state: header bytes load it, payload nibbles advance it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q     <= '0;
			hdr_low_q <= '0;
		end else if (valid_s1) begin
			case (kind_s1)
				KIND_HDR_LO: begin
					hdr_low_q <= byte_s1;
				end
				KIND_HDR_HI: begin
					dec_q.pred <= {byte_s1, hdr_low_q};
				end
				KIND_INDEX: begin
					dec_q.idx <= (byte_s1 > 8'(INDEX_MAX)) ? INDEX_MAX : byte_s1[6:0];
				end
				KIND_PAYLOAD: begin
					if (out_free) begin
						dec_q <= dec_nxt;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sample_q <= dec_nxt.pred;
			last_q   <= phase_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = sample_q;
	assign m_tuser  = last_q;

endmodule

[rtl/imabd_nibble.sv]
// Combinational decode of one ADPCM nibble: predictor and step index update.
// Depends on imabd_pkg for the state struct, step table and index table.
`timescale 1ns / 1ps
module imabd_nibble
	import imabd_pkg::*;
(
	input  imabd_state_t cur,
	input  logic [3:0]   nib,
	output imabd_state_t nxt
);

	logic [16:0]        step;
	logic [16:0]        diff;
	logic signed [17:0] pred_ext;
	logic signed [17:0] sum;
	logic signed [7:0]  idx_sum;

	// Difference built from the shifted step: a base of step/8 plus one term per magnitude bit.
	always_comb begin
		step = {2'b00, step_size(cur.idx)};
		diff = step >> 3;
		if (nib[0]) begin
			diff = diff + (step >> 2);
		end
		if (nib[1]) begin
			diff = diff + (step >> 1);
		end
		if (nib[2]) begin
			diff = diff + step;
		end
	end

	// Apply the difference and saturate the predictor to 16 bits.
	always_comb begin
		pred_ext = 18'(cur.pred);
		if (nib[3]) begin
			sum = pred_ext - $signed({1'b0, diff});
		end else begin
			sum = pred_ext + $signed({1'b0, diff});
		end
		if (sum > PRED_MAX) begin
			nxt.pred = PRED_MAX[15:0];
		end else if (sum < PRED_MIN) begin
			nxt.pred = PRED_MIN[15:0];
		end else begin
			nxt.pred = sum[15:0];
		end
	end

	// Step index update, clamped to the table range.
	always_comb begin
		idx_sum = $signed({1'b0, cur.idx}) + index_adjust(nib[2:0]);
		if (idx_sum < 8'sd0) begin
			nxt.idx = 7'd0;
		end else if (idx_sum > $signed({1'b0, INDEX_MAX})) begin
			nxt.idx = INDEX_MAX;
		end else begin
			nxt.idx = idx_sum[6:0];
		end
	end

endmodule

[rtl/imabd_checker.sv]
// Port-level checks for the IMA ADPCM block decoder, bound to its top level.
// Sees only the top level's ports; no package dependency.
`timescale 1ns / 1ps
module imabd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);

	// A stalled sample holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output sample changed while stalled");

	// The high-nibble sample is ready in the cycle after the low-nibble transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tuser |=> m_tvalid && m_tuser)
		else $error("high-nibble sample did not follow its low-nibble sample");

	// A stalled low-nibble sample keeps the input side from accepting a byte:
	// the decode stage still holds the high nibble of its payload byte and stays busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && !m_tuser && $past(m_tvalid && !m_tready && !m_tuser)
		|-> !s_tready)
		else $error("input accepted while a payload byte is stalled in decode");

	// The register port never inserts wait states.
	assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready deasserted");

endmodule

bind ima_adpcm_block_decoder imabd_checker u_imabd_checker (.*);
